[design/stbc_pkg.sv]
// ----------------------------------------------------------------------------
// stbc_pkg : shared types and constants
// Codes, widths and controller/datapath interface structs for the tilemap and
// box collision block.
// ----------------------------------------------------------------------------
package stbc_pkg;

  localparam int MAP_TILES_DEF   = 4096;
  localparam int MAX_NPCS_DEF    = 16;
  localparam int SPRITE_SPAN_DEF = 32;
  localparam int BOX_SIZE_DEF    = 16;

  localparam int COORD_W    = 16;
  localparam int DIV_W      = 16;
  localparam int CODE_W     = 16;
  localparam int IDX_W      = 12;
  localparam int SLOT_W     = 4;
  localparam int MAPDIM_W   = 7;
  localparam int TDIM_W     = 8;
  localparam int CNT_W      = 5;
  localparam int SRC_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ADDR_W     = 2 * MAPDIM_W;

  // item commands
  localparam logic [1:0] CMD_WRITE_TILE   = 2'd0;
  localparam logic [1:0] CMD_WRITE_NPC    = 2'd1;
  localparam logic [1:0] CMD_PLAYER_QUERY = 2'd2;
  localparam logic [1:0] CMD_NPC_QUERY    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NPC_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CODE  = 3'd5;

  // hit sources
  localparam logic [SRC_W-1:0] SRC_NONE   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_TILE   = 2'd1;
  localparam logic [SRC_W-1:0] SRC_NPC    = 2'd2;
  localparam logic [SRC_W-1:0] SRC_PLAYER = 2'd3;

  // division selects
  localparam logic [1:0] DIV_LEFT   = 2'd0;
  localparam logic [1:0] DIV_RIGHT  = 2'd1;
  localparam logic [1:0] DIV_TOP    = 2'd2;
  localparam logic [1:0] DIV_BOTTOM = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic [1:0] div_sel;
    logic       scan_init;
    logic       tile_read;
    logic       scan_step;
    logic       npc_init;
    logic       npc_read;
    logic       npc_step;
    logic       set_tile;
    logic       set_npc;
    logic       set_player;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_empty;
    logic scan_last;
    logic tile_nz;
    logic tile_hit;
    logic npc_none;
    logic npc_last;
    logic npc_hit;
    logic player_hit;
    logic out_busy;
  } dp_status_t;

endpackage

[design/stbc_div.sv]
// ----------------------------------------------------------------------------
// stbc_div : iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module stbc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [stbc_pkg::DIV_W-1:0]      dividend,
  input  logic [stbc_pkg::TDIM_W-1:0]     divisor,
  output logic                            done,
  output logic [stbc_pkg::DIV_W-1:0]      quotient
);

  localparam int DW = stbc_pkg::DIV_W;
  localparam int RW = stbc_pkg::TDIM_W;
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] count;
  logic [DW-1:0] work;
  logic [RW-1:0] rem;
  logic [RW-1:0] dsr;
  logic [RW:0]   rem_sh;
  logic          ge;

  assign rem_sh   = {rem, work[DW-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CW'(DW);
        work  <= dividend;
        dsr   <= divisor;
        rem   <= '0;
      end else if (count != '0) begin
        count <= count - CW'(1);
        done  <= (count == CW'(1));
        work  <= {work[DW-2:0], ge};
        rem   <= ge ? RW'(rem_sh - {1'b0, dsr}) : rem_sh[RW-1:0];
      end
    end
  end

endmodule

[design/stbc_dp.sv]
// ----------------------------------------------------------------------------
// stbc_dp : datapath
// Registers, tile store, NPC tables, span bounds, box tests and result stage.
// ----------------------------------------------------------------------------
module stbc_dp #(
  parameter int MAP_TILES   = stbc_pkg::MAP_TILES_DEF,
  parameter int MAX_NPCS    = stbc_pkg::MAX_NPCS_DEF,
  parameter int SPRITE_SPAN = stbc_pkg::SPRITE_SPAN_DEF,
  parameter int BOX_SIZE    = stbc_pkg::BOX_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  stbc_pkg::ctrl_cmd_t                 cmd,
  output stbc_pkg::dp_status_t                st,
  input  logic                                cfg_write,
  input  logic [stbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                          command,
  input  logic signed [stbc_pkg::COORD_W-1:0] pos_x,
  input  logic signed [stbc_pkg::COORD_W-1:0] pos_y,
  input  logic signed [stbc_pkg::COORD_W-1:0] avatar_x,
  input  logic signed [stbc_pkg::COORD_W-1:0] avatar_y,
  input  logic [stbc_pkg::IDX_W-1:0]          tile_index,
  input  logic [stbc_pkg::CODE_W-1:0]         tile_value,
  input  logic [stbc_pkg::SLOT_W-1:0]         npc_slot,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [stbc_pkg::CODE_W-1:0]         collision_code,
  output logic [stbc_pkg::SRC_W-1:0]          hit_source
);

  localparam int AW  = $clog2(MAP_TILES);
  localparam int NW  = (MAX_NPCS > 1) ? $clog2(MAX_NPCS) : 1;
  localparam int SW  = $clog2(MAX_NPCS + 1);
  localparam int CW  = stbc_pkg::COORD_W;
  localparam int DW  = stbc_pkg::DIV_W;
  localparam int MW  = stbc_pkg::MAPDIM_W;
  localparam int XW  = CW + 2;
  localparam int ADDR_W = stbc_pkg::ADDR_W;
  localparam logic signed [XW-1:0] BOX_S = XW'(BOX_SIZE);

  function automatic logic meet(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by);
    logic signed [XW-1:0] axe, aye, bxe, bye;
    axe = XW'(ax);
    aye = XW'(ay);
    bxe = XW'(bx);
    bye = XW'(by);
    return (axe < bxe + BOX_S) && (axe + BOX_S > bxe) &&
           (aye < bye + BOX_S) && (aye + BOX_S > bye);
  endfunction

  // configuration
  logic [stbc_pkg::TDIM_W-1:0] tile_width, tile_height;
  logic [MW-1:0]               map_columns, map_rows;
  logic [stbc_pkg::CNT_W-1:0]  npc_count;
  logic [stbc_pkg::CODE_W-1:0] block_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= 8'd8;
      tile_height <= 8'd8;
      map_columns <= 7'd64;
      map_rows    <= 7'd64;
      npc_count   <= '0;
      block_code  <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        stbc_pkg::CFG_TILE_WIDTH:  tile_width  <= cfg_data[stbc_pkg::TDIM_W-1:0];
        stbc_pkg::CFG_TILE_HEIGHT: tile_height <= cfg_data[stbc_pkg::TDIM_W-1:0];
        stbc_pkg::CFG_MAP_COLUMNS: map_columns <= cfg_data[MW-1:0];
        stbc_pkg::CFG_MAP_ROWS:    map_rows    <= cfg_data[MW-1:0];
        stbc_pkg::CFG_NPC_COUNT:   npc_count   <= cfg_data[stbc_pkg::CNT_W-1:0];
        stbc_pkg::CFG_BLOCK_CODE:  block_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched query
  logic [1:0]           cur_cmd;
  logic signed [CW-1:0] qx, qy, px, py;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_cmd <= command;
      qx      <= pos_x;
      qy      <= pos_y;
      px      <= avatar_x;
      py      <= avatar_y;
    end
  end

  // span ends
  logic signed [CW:0] xs, ys;
  assign xs = (CW+1)'(qx) + (CW+1)'(SPRITE_SPAN);
  assign ys = (CW+1)'(qy) + (CW+1)'(SPRITE_SPAN);

  logic [DW-1:0]               dvd;
  logic [stbc_pkg::TDIM_W-1:0] dsr;
  logic                        div_done;
  logic [DW-1:0]               quo;

  // a negative far end is divided by magnitude: truncation toward zero
  always_comb begin
    case (cmd.div_sel)
      stbc_pkg::DIV_LEFT:   dvd = qx[CW-1] ? '0 : DW'(qx);
      stbc_pkg::DIV_RIGHT:  dvd = xs[CW]   ? DW'(-xs) : xs[DW-1:0];
      stbc_pkg::DIV_TOP:    dvd = qy[CW-1] ? '0 : DW'(qy);
      default:              dvd = ys[CW]   ? DW'(-ys) : ys[DW-1:0];
    endcase
    if (cmd.div_sel[1]) dsr = (tile_height == '0) ? 8'd1 : tile_height;
    else                dsr = (tile_width  == '0) ? 8'd1 : tile_width;
  end

  stbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (quo)
  );

  logic [DW-1:0] q_left, q_right, q_top, q_bot;

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_sel)
        stbc_pkg::DIV_LEFT:  q_left  <= quo;
        stbc_pkg::DIV_RIGHT: q_right <= quo;
        stbc_pkg::DIV_TOP:   q_top   <= quo;
        default:             q_bot   <= quo;
      endcase
    end
  end

  // far end below zero only when the magnitude reaches a whole tile
  logic          right_neg, bot_neg;
  logic [DW-1:0] right_q, bot_q;
  assign right_neg = xs[CW] && q_right != '0;
  assign bot_neg   = ys[CW] && q_bot != '0;
  assign right_q   = xs[CW] ? '0 : q_right;
  assign bot_q     = ys[CW] ? '0 : q_bot;

  logic [DW-1:0] cols_m1, rows_m1, right_c, bot_c;
  assign cols_m1 = DW'(map_columns) - DW'(1);
  assign rows_m1 = DW'(map_rows) - DW'(1);
  assign right_c = (right_q > cols_m1) ? cols_m1 : right_q;
  assign bot_c   = (bot_q > rows_m1) ? rows_m1 : bot_q;

  // tile scan
  logic [MW-1:0]     col, row;
  logic [ADDR_W-1:0] addr;
  logic              addr_ok;

  assign addr    = ADDR_W'(row) * ADDR_W'(map_columns) + ADDR_W'(col);
  assign addr_ok = 17'(addr) < 17'(MAP_TILES);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      col <= q_left[MW-1:0];
      row <= q_top[MW-1:0];
    end else if (cmd.scan_step) begin
      if (row == bot_c[MW-1:0]) begin
        row <= q_top[MW-1:0];
        col <= col + MW'(1);
      end else begin
        row <= row + MW'(1);
      end
    end
  end

  logic [stbc_pkg::CODE_W-1:0] tile_mem [MAP_TILES];
  logic [stbc_pkg::CODE_W-1:0] tile_rd;
  logic                        tile_ok;
  logic [stbc_pkg::CODE_W-1:0] tile_val;

  always_ff @(posedge clk) begin
    if (cmd.accept && command == stbc_pkg::CMD_WRITE_TILE &&
        17'(tile_index) < 17'(MAP_TILES))
      tile_mem[AW'(tile_index)] <= tile_value;
    if (cmd.tile_read) begin
      tile_rd <= tile_mem[AW'(addr)];
      tile_ok <= addr_ok;
    end
  end

  assign tile_val = tile_ok ? tile_rd : '0;

  // NPC table
  logic [CW-1:0] npc_x_mem [MAX_NPCS];
  logic [CW-1:0] npc_y_mem [MAX_NPCS];
  logic signed [CW-1:0] nx, ny;
  logic [SW-1:0] npc_idx, npc_lim;

  assign npc_lim = (32'(npc_count) >= MAX_NPCS) ? SW'(MAX_NPCS) : SW'(npc_count);

  always_ff @(posedge clk) begin
    if (cmd.accept && command == stbc_pkg::CMD_WRITE_NPC && 32'(npc_slot) < MAX_NPCS) begin
      npc_x_mem[NW'(npc_slot)] <= pos_x;
      npc_y_mem[NW'(npc_slot)] <= pos_y;
    end
    if (cmd.npc_read) begin
      nx <= npc_x_mem[NW'(npc_idx)];
      ny <= npc_y_mem[NW'(npc_idx)];
    end
    if (cmd.npc_init)      npc_idx <= '0;
    else if (cmd.npc_step) npc_idx <= npc_idx + SW'(1);
  end

  logic npc_self;
  assign npc_self = (cur_cmd == stbc_pkg::CMD_NPC_QUERY) && nx == qx && ny == qy;

  // status
  always_comb begin
    st.div_done   = div_done;
    st.scan_empty = right_neg || bot_neg || map_columns == '0 || map_rows == '0 ||
                    q_left > right_c || q_top > bot_c;
    st.scan_last  = col == right_c[MW-1:0] && row == bot_c[MW-1:0];
    st.tile_nz    = tile_val != '0;
    st.tile_hit   = (cur_cmd == stbc_pkg::CMD_PLAYER_QUERY) || tile_val == block_code;
    st.npc_none   = npc_lim == '0;
    st.npc_last   = npc_idx == npc_lim - SW'(1);
    st.npc_hit    = !npc_self && meet(qx, qy, nx, ny);
    st.player_hit = (cur_cmd == stbc_pkg::CMD_NPC_QUERY) && meet(qx, qy, px, py);
    st.out_busy   = out_valid && out_stall;
  end

  // result
  logic [stbc_pkg::CODE_W-1:0] res_code;
  logic [stbc_pkg::SRC_W-1:0]  res_src;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_code <= '0;
      res_src  <= stbc_pkg::SRC_NONE;
    end else if (cmd.set_tile) begin
      res_code <= tile_val;
      res_src  <= stbc_pkg::SRC_TILE;
    end else if (cmd.set_npc) begin
      res_code <= block_code;
      res_src  <= stbc_pkg::SRC_NPC;
    end else if (cmd.set_player) begin
      res_code <= block_code;
      res_src  <= stbc_pkg::SRC_PLAYER;
    end
    if (cmd.load_out) begin
      collision_code <= res_code;
      hit_source     <= res_src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (!out_stall)   out_valid <= 1'b0;
  end

endmodule

[design/stbc_ctrl.sv]
// ----------------------------------------------------------------------------
// stbc_ctrl : controller
// Sequences the span divisions, the tile scan, the NPC scan and the result.
// ----------------------------------------------------------------------------
module stbc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            command,
  output logic                  in_stall,
  output stbc_pkg::ctrl_cmd_t   cmd,
  input  stbc_pkg::dp_status_t  st
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_SCAN_INIT, S_SCAN_ADDR, S_SCAN_DATA,
    S_NPC_INIT, S_NPC_ADDR, S_NPC_DATA, S_PLAYER, S_DONE
  } state_t;

  state_t     state;
  logic [1:0] div_idx;
  logic       accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && state == S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.div_sel    = div_idx;
    cmd.div_start  = state == S_DIV_GO;
    cmd.scan_init  = state == S_SCAN_INIT;
    cmd.tile_read  = state == S_SCAN_ADDR;
    cmd.scan_step  = state == S_SCAN_DATA && !st.tile_nz && !st.scan_last;
    cmd.set_tile   = state == S_SCAN_DATA && st.tile_nz && st.tile_hit;
    cmd.npc_init   = state == S_NPC_INIT;
    cmd.npc_read   = state == S_NPC_ADDR;
    cmd.npc_step   = state == S_NPC_DATA && !st.npc_hit && !st.npc_last;
    cmd.set_npc    = state == S_NPC_DATA && st.npc_hit;
    cmd.set_player = state == S_PLAYER && st.player_hit;
    cmd.load_out   = state == S_DONE && !st.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_idx <= stbc_pkg::DIV_LEFT;
    end else begin
      case (state)
        S_IDLE: begin
          div_idx <= stbc_pkg::DIV_LEFT;
          if (accept && (command == stbc_pkg::CMD_PLAYER_QUERY ||
                         command == stbc_pkg::CMD_NPC_QUERY))
            state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (st.div_done) begin
            if (div_idx == stbc_pkg::DIV_BOTTOM) begin
              state <= S_SCAN_INIT;
            end else begin
              div_idx <= div_idx + 2'd1;
              state   <= S_DIV_GO;
            end
          end
        end
        S_SCAN_INIT: state <= st.scan_empty ? S_NPC_INIT : S_SCAN_ADDR;
        S_SCAN_ADDR: state <= S_SCAN_DATA;
        S_SCAN_DATA: begin
          if (st.tile_nz)          state <= st.tile_hit ? S_DONE : S_NPC_INIT;
          else if (st.scan_last)   state <= S_NPC_INIT;
          else                     state <= S_SCAN_ADDR;
        end
        S_NPC_INIT: state <= st.npc_none ? S_PLAYER : S_NPC_ADDR;
        S_NPC_ADDR: state <= S_NPC_DATA;
        S_NPC_DATA: begin
          if (st.npc_hit)        state <= S_DONE;
          else if (st.npc_last)  state <= S_PLAYER;
          else                   state <= S_NPC_ADDR;
        end
        S_PLAYER: state <= S_DONE;
        S_DONE:   if (!st.out_busy) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/sprite_tilemap_box_collision_top.sv]
// ----------------------------------------------------------------------------
// sprite_tilemap_box_collision_top : tilemap and box collision engine
// Tile store and NPC table written by items; queries scan tiles then boxes.
// ----------------------------------------------------------------------------
// Writes (tile or NPC) leave the controller idle: the next beat is taken straight after.
// Query: four span divisions on one shared 16-step divider, then the scan init and
// an address and a data state per tile scanned, the NPC init and an address and a
// data state per NPC tested, the player box test, then the load; an early hit cuts
// the scans short; the next beat can be taken as out_valid rises.
// A waiting result holds the next query in its last cycle. rst (sync) idles, drops
// out_valid and reloads the registers; tile and NPC stores are not cleared.
// ----------------------------------------------------------------------------
module sprite_tilemap_box_collision_top #(
  parameter int MAP_TILES   = stbc_pkg::MAP_TILES_DEF,
  parameter int MAX_NPCS    = stbc_pkg::MAX_NPCS_DEF,
  parameter int SPRITE_SPAN = stbc_pkg::SPRITE_SPAN_DEF,
  parameter int BOX_SIZE    = stbc_pkg::BOX_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [stbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic signed [stbc_pkg::COORD_W-1:0] pos_x,
  input  logic signed [stbc_pkg::COORD_W-1:0] pos_y,
  input  logic signed [stbc_pkg::COORD_W-1:0] avatar_x,
  input  logic signed [stbc_pkg::COORD_W-1:0] avatar_y,
  input  logic [stbc_pkg::IDX_W-1:0]          tile_index,
  input  logic [stbc_pkg::CODE_W-1:0]         tile_value,
  input  logic [stbc_pkg::SLOT_W-1:0]         npc_slot,
  // result beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stbc_pkg::CODE_W-1:0]         collision_code,
  output logic [stbc_pkg::SRC_W-1:0]          hit_source
);

  stbc_pkg::ctrl_cmd_t  cmd;
  stbc_pkg::dp_status_t st;

  // controller: decides what the datapath does each cycle
  stbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  // datapath: stores, divider, box tests, output register
  stbc_dp #(
    .MAP_TILES   (MAP_TILES),
    .MAX_NPCS    (MAX_NPCS),
    .SPRITE_SPAN (SPRITE_SPAN),
    .BOX_SIZE    (BOX_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .avatar_x       (avatar_x),
    .avatar_y       (avatar_y),
    .tile_index     (tile_index),
    .tile_value     (tile_value),
    .npc_slot       (npc_slot),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .collision_code (collision_code),
    .hit_source     (hit_source)
  );

endmodule

[design/stbc_checker.sv]
// ----------------------------------------------------------------------------
// stbc_checker : port-level checks
// Watches the top level's ports and flags broken beats or results.
// ----------------------------------------------------------------------------
module stbc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [1:0]                      command,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [stbc_pkg::CODE_W-1:0]     collision_code,
  input logic [stbc_pkg::SRC_W-1:0]      hit_source
);

  // a result beat held back stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // no hit means a zero code
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_source == stbc_pkg::SRC_NONE |-> collision_code == '0)
    else $error("nonzero code with no hit");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

  // a write beat never holds up the next beat
  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
    (command == stbc_pkg::CMD_WRITE_TILE || command == stbc_pkg::CMD_WRITE_NPC)
    |=> !in_stall)
    else $error("stall after write beat");

endmodule

bind sprite_tilemap_box_collision_top stbc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .command        (command),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .collision_code (collision_code),
  .hit_source     (hit_source)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the tilemap and box collision engine
// Fills the reachable part of the tile store and the NPC table, then runs
// directed corner queries, a sweep of register settings, a back-pressure test
// and a long random phase. Every result beat is checked against a predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 200;   // cycles allowed after the last result
  localparam int SPAN        = 32;
  localparam int BOX         = 16;
  localparam int TILES       = 4096;
  localparam int NPCS        = 16;
  localparam int FILL        = 1024;  // every map setting keeps columns x rows within this

  typedef struct {
    logic [stbc_pkg::CODE_W-1:0] code;
    logic [stbc_pkg::SRC_W-1:0]  src;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [stbc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [stbc_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          command = stbc_pkg::CMD_WRITE_TILE;
  logic signed [stbc_pkg::COORD_W-1:0] pos_x = '0, pos_y = '0, avatar_x = '0, avatar_y = '0;
  logic [stbc_pkg::IDX_W-1:0]          tile_index = '0;
  logic [stbc_pkg::CODE_W-1:0]         tile_value = '0;
  logic [stbc_pkg::SLOT_W-1:0]         npc_slot = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [stbc_pkg::CODE_W-1:0]         collision_code;
  logic [stbc_pkg::SRC_W-1:0]          hit_source;

  sprite_tilemap_box_collision_top dut (.*);

  always #5 clk = ~clk;

  // predictor state: register copies and mirrored stores
  int cw = 8, ch = 8, cols = 64, rows = 64, ncnt = 0, bcode = 1;
  logic [stbc_pkg::CODE_W-1:0]  tile_mirror [TILES];
  logic [stbc_pkg::COORD_W-1:0] npc_x_mirror [NPCS];
  logic [stbc_pkg::COORD_W-1:0] npc_y_mirror [NPCS];

  hit_t pending_hits[$];
  int   err_count = 0;
  int   cycles = 0;
  bit   tx_idle_en = 1'b0;
  bit   rx_idle_en = 1'b0;
  bit   rx_hold = 1'b0;

  // ---- prediction ---------------------------------------------------------
  function automatic int first_tile(int x, int y);
    int tw, th, left, right, top, bottom, addr;
    tw = (cw == 0) ? 1 : cw;
    th = (ch == 0) ? 1 : ch;
    left = x / tw;  right = (x + SPAN) / tw;   // signed, truncates to zero
    top  = y / th;  bottom = (y + SPAN) / th;
    if (left < 0) left = 0;
    if (top < 0) top = 0;
    if (right > cols - 1) right = cols - 1;
    if (bottom > rows - 1) bottom = rows - 1;
    for (int c = left; c <= right; c++)
      for (int r = top; r <= bottom; r++) begin
        addr = r * cols + c;
        if (addr < TILES && tile_mirror[addr] != 0) return tile_mirror[addr];
      end
    return 0;
  endfunction

  function automatic bit boxes_overlap(int x, int y, int bx, int by);
    return x < bx + BOX && x + BOX > bx && y < by + BOX && y + BOX > by;
  endfunction

  function automatic hit_t predict_hit(logic [1:0] cmd, int x, int y, int px, int py);
    hit_t h;
    int t, n, nx, ny;
    h.code = '0;
    h.src  = stbc_pkg::SRC_NONE;
    t = first_tile(x, y);
    if (cmd == stbc_pkg::CMD_PLAYER_QUERY ? t != 0 : (t != 0 && t == bcode)) begin
      h.code = t[stbc_pkg::CODE_W-1:0];
      h.src  = stbc_pkg::SRC_TILE;
    end
    n = (ncnt < NPCS) ? ncnt : NPCS;
    for (int s = 0; s < n && h.src == stbc_pkg::SRC_NONE; s++) begin
      nx = int'($signed(npc_x_mirror[s]));
      ny = int'($signed(npc_y_mirror[s]));
      // an NPC query ignores the NPC sitting exactly on its own position
      if (!(cmd == stbc_pkg::CMD_NPC_QUERY && nx == x && ny == y) &&
          boxes_overlap(x, y, nx, ny)) begin
        h.code = bcode[stbc_pkg::CODE_W-1:0];
        h.src  = stbc_pkg::SRC_NPC;
      end
    end
    if (h.src == stbc_pkg::SRC_NONE && cmd == stbc_pkg::CMD_NPC_QUERY &&
        boxes_overlap(x, y, px, py)) begin
      h.code = bcode[stbc_pkg::CODE_W-1:0];
      h.src  = stbc_pkg::SRC_PLAYER;
    end
    return h;
  endfunction

  // ---- cycle limit --------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- result checking ----------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    hit_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0)
        report_mismatch("unexpected result beat", collision_code, 0);
      else begin
        want = pending_hits.pop_front();
        if (collision_code !== want.code)
          report_mismatch("collision_code", collision_code, want.code);
        if (hit_source !== want.src)
          report_mismatch("hit_source", hit_source, want.src);
      end
    end
  end

  // ---- receiver stall: random bursts, or a long hold when asked -----------
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (rx_hold) out_stall = 1'b1;
      else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 13);
        out_stall = 1'b1;
      end else out_stall = 1'b0;
    end
  end

  // ---- drivers ------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(logic [1:0] cmd, int x, int y, int px, int py,
                           int idx, int val, int slot);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    command = cmd;
    pos_x = x[15:0];  pos_y = y[15:0];
    avatar_x = px[15:0];  avatar_y = py[15:0];
    tile_index = idx[stbc_pkg::IDX_W-1:0];
    tile_value = val[stbc_pkg::CODE_W-1:0];
    npc_slot = slot[stbc_pkg::SLOT_W-1:0];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    // beat accepted: update mirrors or queue the expected hit
    case (command)
      stbc_pkg::CMD_WRITE_TILE: tile_mirror[tile_index] = tile_value;
      stbc_pkg::CMD_WRITE_NPC: begin
        npc_x_mirror[npc_slot] = pos_x;
        npc_y_mirror[npc_slot] = pos_y;
      end
      default: pending_hits.push_back(predict_hit(command, int'(pos_x), int'(pos_y),
                                                  int'(avatar_x), int'(avatar_y)));
    endcase
    @(negedge clk);
  endtask

  task automatic set_reg(logic [stbc_pkg::CFG_IDX_W-1:0] idx, int val);
    in_valid = 1'b0;
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val[stbc_pkg::CFG_DATA_W-1:0];
    case (idx)
      stbc_pkg::CFG_TILE_WIDTH:  cw = val & 8'hFF;
      stbc_pkg::CFG_TILE_HEIGHT: ch = val & 8'hFF;
      stbc_pkg::CFG_MAP_COLUMNS: cols = val & 7'h7F;
      stbc_pkg::CFG_MAP_ROWS:    rows = val & 7'h7F;
      stbc_pkg::CFG_NPC_COUNT:   ncnt = val & 5'h1F;
      stbc_pkg::CFG_BLOCK_CODE:  bcode = val & 16'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_all(int tw, int th, int c, int r, int n, int b);
    set_reg(stbc_pkg::CFG_TILE_WIDTH, tw);
    set_reg(stbc_pkg::CFG_TILE_HEIGHT, th);
    set_reg(stbc_pkg::CFG_MAP_COLUMNS, c);
    set_reg(stbc_pkg::CFG_MAP_ROWS, r);
    set_reg(stbc_pkg::CFG_NPC_COUNT, n);
    set_reg(stbc_pkg::CFG_BLOCK_CODE, b);
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic drain_hits();
    in_valid = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // ---- random beats -------------------------------------------------------
  function automatic int near_coord();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 600)) - 40;
  endfunction

  function automatic int pick_code();
    case ($urandom_range(0, 4))
      0:       return bcode;
      1:       return 16'hFFFF;
      2:       return $urandom_range(1, 65535);
      default: return 0;
    endcase
  endfunction

  task automatic random_beat();
    int sel, x, y, px, py, s;
    sel = $urandom_range(0, 19);
    x = near_coord();
    y = near_coord();
    px = x + int'($urandom_range(0, 40)) - 20;
    py = y + int'($urandom_range(0, 40)) - 20;
    if (sel < 2)
      send_beat(stbc_pkg::CMD_WRITE_TILE, x, y, px, py, $urandom_range(0, 4095),
                pick_code(), $urandom_range(0, 15));
    else if (sel < 4)
      send_beat(stbc_pkg::CMD_WRITE_NPC, x, y, px, py, $urandom_range(0, 4095),
                pick_code(), $urandom_range(0, 15));
    else if (sel < 11)
      send_beat(stbc_pkg::CMD_PLAYER_QUERY, x, y, px, py, $urandom_range(0, 4095),
                $urandom_range(0, 65535), $urandom_range(0, 15));
    else begin
      // a share of NPC queries sits on an NPC so the self skip is exercised
      if (sel < 14) begin
        s = $urandom_range(0, NPCS - 1);
        x = int'($signed(npc_x_mirror[s]));
        y = int'($signed(npc_y_mirror[s]));
      end
      if ($urandom_range(0, 1)) begin
        px = near_coord();
        py = near_coord();
      end
      send_beat(stbc_pkg::CMD_NPC_QUERY, x, y, px, py, $urandom_range(0, 4095),
                $urandom_range(0, 65535), $urandom_range(0, 15));
    end
  endtask

  task automatic random_run(int n);
    repeat (n) random_beat();
  endtask

  // ---- tests --------------------------------------------------------------
  // The first FILL tiles and every NPC entry are written first; with columns x
  // rows kept within FILL no query reads an unwritten entry. The map is sparse
  // so that box checks get reached.
  task automatic test_fill();
    int v;
    for (int i = 0; i < FILL; i++) begin
      v = ($urandom_range(0, 24) == 0) ? pick_code() : 0;
      send_beat(stbc_pkg::CMD_WRITE_TILE, 0, 0, 0, 0, i, v, 0);
    end
    for (int s = 0; s < NPCS; s++)
      send_beat(stbc_pkg::CMD_WRITE_NPC, $urandom_range(0, 500), $urandom_range(0, 500),
                0, 0, 0, 0, s);
  endtask

  task automatic test_directed();
    set_reg(stbc_pkg::CFG_MAP_COLUMNS, 32);
    set_reg(stbc_pkg::CFG_MAP_ROWS, 32);
    set_reg(stbc_pkg::CFG_NPC_COUNT, 16);
    // extreme slot and index, extreme coordinates in the table
    send_beat(stbc_pkg::CMD_WRITE_TILE, 0, 0, 0, 0, 4095, 16'hFFFF, 0);
    send_beat(stbc_pkg::CMD_WRITE_NPC, 32767, -32768, 0, 0, 4095, 0, 15);
    send_beat(stbc_pkg::CMD_WRITE_NPC, 100, 200, 0, 0, 0, 0, 0);
    send_beat(stbc_pkg::CMD_WRITE_NPC, 100, 260, 0, 0, 0, 0, 1);
    // coordinate extremes for both queries
    send_beat(stbc_pkg::CMD_PLAYER_QUERY, -32768, -32768, 0, 0, 0, 0, 0);
    send_beat(stbc_pkg::CMD_PLAYER_QUERY, 32767, 32767, 0, 0, 0, 0, 0);
    send_beat(stbc_pkg::CMD_PLAYER_QUERY, 32767, -32768, 0, 0, 0, 0, 0);
    send_beat(stbc_pkg::CMD_NPC_QUERY, 32767, -32768, 32767, -32768, 0, 0, 0);
    send_beat(stbc_pkg::CMD_NPC_QUERY, -32768, 32767, -32768, 32767, 0, 0, 0);
    send_beat(stbc_pkg::CMD_PLAYER_QUERY, 0, 0, 0, 0, 0, 0, 0);
    // far end just below zero still covers the first column and row
    send_beat(stbc_pkg::CMD_PLAYER_QUERY, -35, -35, 0, 0, 0, 0, 0);
    // self skip: exact match skipped, one coordinate equal is not
    send_beat(stbc_pkg::CMD_NPC_QUERY, 100, 200, -1000, -1000, 0, 0, 0);
    send_beat(stbc_pkg::CMD_NPC_QUERY, 100, 205, -1000, -1000, 0, 0, 0);
    send_beat(stbc_pkg::CMD_NPC_QUERY, 105, 200, -1000, -1000, 0, 0, 0);
    // player box hit and near miss
    send_beat(stbc_pkg::CMD_NPC_QUERY, -3000, -3000, -2985, -2985, 0, 0, 0);
    send_beat(stbc_pkg::CMD_NPC_QUERY, -3000, -3000, -2984, -3000, 0, 0, 0);
    send_beat(stbc_pkg::CMD_PLAYER_QUERY, 100, 244, 0, 0, 0, 0, 0);
    send_beat(stbc_pkg::CMD_PLAYER_QUERY, 504, 504, 0, 0, 0, 0, 0);
    drain_hits();
  endtask

  task automatic test_reg_sweep();
    // extremes of tile size and map size, count beyond table, code zero
    set_all(255, 255, 1, 1, 0, 1);      random_run(40);  drain_hits();
    set_all(16, 16, 32, 32, 5, 16'hFFFF); random_run(60); drain_hits();
    set_all(0, 0, 127, 8, 31, 0);       random_run(15);  drain_hits();
    set_all(1, 1, 64, 16, 16, 1);       random_run(15);  drain_hits();
    set_all(12, 7, 0, 10, 8, 5);        random_run(40);  drain_hits();
    set_all(8, 8, 64, 0, 16, 0);        random_run(40);  drain_hits();
  endtask

  task automatic test_backpressure();
    set_all(8, 8, 32, 32, 16, 1);
    rx_hold = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (30) send_beat(stbc_pkg::CMD_PLAYER_QUERY, near_coord(), near_coord(),
                          0, 0, 0, 0, 0);
    drain_hits();
  endtask

  task automatic test_random_long();
    int c;
    for (int phase = 0; phase < 8; phase++) begin
      c = $urandom_range(1, 64);
      set_all($urandom_range(6, 32), $urandom_range(6, 32), c,
              $urandom_range(1, FILL / c), $urandom_range(0, 16), pick_code());
      tx_idle_en = (phase < 6);
      rx_idle_en = (phase < 6) && (phase != 2);
      random_run(50);
      if (phase == 3) drain_hits();   // sender waits out all results mid-phase
      random_run(50);
      drain_hits();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_fill();
    drain_hits();
    test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_reg_sweep();
    test_backpressure();
    test_random_long();
    drain_hits();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
